### src/mbd_pkg.sv
// ----------------------------------------------------------------------------
// mbd_pkg: shared constants for the moving-boundary diffusion column
// Field widths, fixed-point format and the default column depth.
// ----------------------------------------------------------------------------
package mbd_pkg;

    localparam int CELLS_DEFAULT = 128;

    localparam int DATA_W  = 24;   // Q8.16 concentration and level
    localparam int FRAC_W  = 16;   // fraction bits of every Q format
    localparam int R_W     = 16;   // diffusion number, Q0.16
    localparam int DROP_W  = 24;   // level drop, Q8.16
    localparam int CIDX_W  = 7;    // cell index of a read word
    localparam int LVLO_W  = 8;    // surface index in the result word

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 32;

    localparam logic [DATA_W-1:0] ONE_Q16  = 24'h010000;
    localparam logic [DATA_W-1:0] MAX_CELL = 24'hFFFFFF;

    // Input word kinds carried on s_tuser.
    localparam logic KIND_STEP = 1'b0;
    localparam logic KIND_READ = 1'b1;

endpackage

### src/mbd_column_ram.sv
// ----------------------------------------------------------------------------
// mbd_column_ram: concentration store of the column
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mbd_column_ram #(
    parameter int DEPTH  = mbd_pkg::CELLS_DEFAULT,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int WORD_W = mbd_pkg::DATA_W
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### src/mbd_stencil_unit.sv
// ----------------------------------------------------------------------------
// mbd_stencil_unit: shared scaling unit of the stencil
// Multiplies a signed second difference by the diffusion number and rounds
// the product to Q8.16, ties away from zero.
// ----------------------------------------------------------------------------
module mbd_stencil_unit #(
    parameter int DELTA_W = 37,
    parameter int TERM_W  = DELTA_W + 2
) (
    input  logic                           aclk,
    input  logic                           en,
    input  logic signed [DELTA_W-1:0]      delta,
    input  logic        [mbd_pkg::R_W-1:0] r,
    output logic signed [TERM_W-1:0]       term
);

    localparam int PROD_W = DELTA_W + mbd_pkg::R_W;

    logic [DELTA_W-1:0]  mag;
    logic [PROD_W-1:0]   prod_reg;
    logic                neg_reg;
    logic [PROD_W:0]     rounded;
    logic [TERM_W-2:0]   scaled;

    assign mag = delta[DELTA_W-1] ? DELTA_W'(-delta) : DELTA_W'(delta);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PROD_W'(mag) * PROD_W'(r);
            neg_reg  <= delta[DELTA_W-1];
        end
    end

    // Round the magnitude, then put the sign back.
    assign rounded = (PROD_W+1)'(prod_reg) + (PROD_W+1)'(1 << (mbd_pkg::FRAC_W - 1));
    assign scaled  = rounded[PROD_W:mbd_pkg::FRAC_W];
    assign term    = neg_reg ? -$signed({1'b0, scaled}) : $signed({1'b0, scaled});

endmodule

### src/moving_boundary_diffusion_step.sv
// ----------------------------------------------------------------------------
// moving_boundary_diffusion_step: 1-D diffusion column under a falling surface
// A step word gathers solute from newly dry cells into the top wet cell, runs
// an explicit three-point stencil with a reflective bottom, keeps the column
// total in the top wet cell and lowers the surface. A read word returns a cell.
//
//  channel  ports            contents (lowest bit first)
//  -------  ---------------  ---------------------------------------------------
//  s_       tvalid/tready    tuser: kind; tdata: diffusion_number, level_drop,
//                            cell_index
//  m_       tvalid/tready    tdata: cell_value, level_index
//
// A read word passes through ST_READ to ST_DONE. A step word sweeps the whole
// column in ST_SUM to total, gather and clear, then takes each wet cell below
// the top one, if any, through the shared multiplier (ST_LOAD once, then ST_DELTA,
// ST_MUL and ST_UPD per cell) and writes the top cell in ST_TOP.
// After reset the block sweeps every cell of the column to 1.0, s_tready low.
// One word is worked on at a time; a finished result waits in the output
// register while the next word is accepted.
// ----------------------------------------------------------------------------
module moving_boundary_diffusion_step #(
    parameter int CELLS = mbd_pkg::CELLS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // diffusion_number[15:0], level_drop[39:16], cell_index[46:40], zero pad
    input  logic [mbd_pkg::S_TDATA_W-1:0]   s_tdata,
    // kind[0]
    input  logic [0:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // cell_value[23:0], level_index[31:24]
    output logic [mbd_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int DW   = mbd_pkg::DATA_W;
    localparam int FW16 = mbd_pkg::FRAC_W;
    localparam int AW   = $clog2(CELLS);
    localparam int IW   = $clog2(CELLS + 1);
    localparam int SW   = DW + AW;            // column total
    localparam int DTW  = SW + 3;             // second difference
    localparam int TW   = DTW + 2;            // scaled stencil term
    localparam int FRW  = TW + 1;             // updated cell before saturation
    localparam int LW   = IW + FW16;          // surface level
    localparam int LCW  = (LW > mbd_pkg::DROP_W) ? LW : mbd_pkg::DROP_W;
    localparam int RW   = IW + 1;             // rounded level

    typedef enum logic [9:0] {
        ST_INIT  = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_READ  = 10'b0000000100,
        ST_SUM   = 10'b0000001000,
        ST_LOAD  = 10'b0000010000,
        ST_DELTA = 10'b0000100000,
        ST_MUL   = 10'b0001000000,
        ST_UPD   = 10'b0010000000,
        ST_TOP   = 10'b0100000000,
        ST_DONE  = 10'b1000000000
    } state_t;

    function automatic logic [DW-1:0] sat_cell(input logic signed [63:0] v);
        logic [DW-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > 64'(mbd_pkg::MAX_CELL)) begin
            res = mbd_pkg::MAX_CELL;
        end else begin
            res = v[DW-1:0];
        end
        return res;
    endfunction

    state_t state_reg, state_next;

    logic [IW-1:0]  cnt_reg;
    logic [IW-1:0]  idx_reg;
    logic [IW-1:0]  prev_reg;
    logic [LW-1:0]  level_reg;
    logic           m_valid_reg;
    logic [DW-1:0]  m_value_reg;
    logic [mbd_pkg::LVLO_W-1:0] m_level_reg;

    logic [mbd_pkg::R_W-1:0]    r_reg;
    logic [mbd_pkg::DROP_W-1:0] drop_reg;
    logic                       rd_ok_reg;
    logic [SW-1:0]              total_reg;
    logic [SW-1:0]              gathered_reg;
    logic [SW-1:0]              below_reg;
    logic [SW-1:0]              w_prev_reg;
    logic [SW-1:0]              w_cur_reg;
    logic [SW-1:0]              w_next_reg;
    logic signed [DTW-1:0]      delta_reg;
    logic [DW-1:0]              res_value_reg;

    logic                       s_fire;
    logic                       s_kind;
    logic [mbd_pkg::R_W-1:0]    s_r;
    logic [mbd_pkg::DROP_W-1:0] s_drop;
    logic [mbd_pkg::CIDX_W-1:0] s_cell;

    logic           ram_wr_en;
    logic [AW-1:0]  ram_wr_addr;
    logic [DW-1:0]  ram_wr_data;
    logic [AW-1:0]  ram_rd_addr;
    logic [DW-1:0]  ram_rd_data;

    logic [LW:0]    level_sum;
    logic [RW-1:0]  level_rnd;
    logic [IW-1:0]  idx_new;
    logic [IW-1:0]  cnt_m1;
    logic [IW-1:0]  cnt_p1;
    logic [IW-1:0]  cnt_p2;
    logic [IW-1:0]  idx_m1;
    logic           sum_data_ok;
    logic [SW-1:0]  s_next;
    logic signed [DTW-1:0] delta;
    logic signed [TW-1:0]  term;
    logic signed [FRW-1:0] fresh;
    logic [DW-1:0]  fresh_sat;
    logic signed [SW:0] top_val;
    logic [DW-1:0]  top_sat;
    logic [LCW-1:0] level_ext;
    logic [LCW-1:0] drop_ext;
    logic           out_free;

    assign s_kind = s_tuser[0];
    assign s_r    = s_tdata[15:0];
    assign s_drop = s_tdata[39:16];
    assign s_cell = s_tdata[46:40];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_level_reg, m_value_reg};
    assign out_free = !m_valid_reg || m_tready;

    // Surface index: level rounded half up, held within [1, CELLS].
    assign level_sum = (LW+1)'(level_reg) + (LW+1)'(1 << (FW16 - 1));
    assign level_rnd = level_sum[LW:FW16];

    always_comb begin
        if (level_rnd == '0) begin
            idx_new = IW'(1);
        end else if (level_rnd > RW'(CELLS)) begin
            idx_new = IW'(CELLS);
        end else begin
            idx_new = IW'(level_rnd);
        end
    end

    assign cnt_m1 = cnt_reg - IW'(1);
    assign cnt_p1 = cnt_reg + IW'(1);
    assign cnt_p2 = cnt_reg + IW'(2);
    assign idx_m1 = idx_reg - IW'(1);
    assign sum_data_ok = (cnt_reg != '0);

    // The top wet cell enters the stencil with the gathered solute added.
    assign s_next = SW'(ram_rd_data) + ((cnt_p1 == idx_m1) ? gathered_reg : '0);
    assign delta  = $signed(DTW'(s_next)) - $signed(DTW'({w_cur_reg, 1'b0}))
                    + $signed(DTW'(w_prev_reg));

    assign fresh     = $signed(FRW'(w_cur_reg)) + FRW'(term);
    assign fresh_sat = sat_cell(64'(fresh));
    assign top_val   = $signed({1'b0, total_reg}) - $signed({1'b0, below_reg});
    assign top_sat   = sat_cell(64'(top_val));

    assign level_ext = LCW'(level_reg);
    assign drop_ext  = LCW'(drop_reg);

    mbd_column_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (AW),
        .WORD_W (DW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    mbd_stencil_unit #(
        .DELTA_W (DTW),
        .TERM_W  (TW)
    ) u_stencil (
        .aclk  (aclk),
        .en    (state_reg == ST_MUL),
        .delta (delta_reg),
        .r     (r_reg),
        .term  (term)
    );

    // Memory port steering.
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = cnt_reg[AW-1:0];
        ram_wr_data = '0;
        ram_rd_addr = '0;
        unique case (state_reg)
            ST_INIT: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = mbd_pkg::ONE_Q16;
            end
            ST_IDLE: begin
                ram_rd_addr = AW'(s_cell);
            end
            ST_SUM: begin
                // Cells at or above the new surface clear once they are summed.
                ram_wr_en   = sum_data_ok && (cnt_m1 >= idx_reg);
                ram_wr_addr = cnt_m1[AW-1:0];
                ram_rd_addr = (cnt_reg < IW'(CELLS)) ? cnt_reg[AW-1:0] : '0;
            end
            ST_LOAD: begin
                ram_rd_addr = AW'(1);
            end
            ST_UPD: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = fresh_sat;
                ram_rd_addr = cnt_p2[AW-1:0];
            end
            ST_TOP: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_m1[AW-1:0];
                ram_wr_data = top_sat;
            end
            ST_READ, ST_DELTA, ST_MUL, ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (cnt_reg == IW'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = (s_kind == mbd_pkg::KIND_READ) ? ST_READ : ST_SUM;
                end
            end
            ST_READ: state_next = ST_DONE;
            ST_SUM: begin
                if (cnt_reg == IW'(CELLS)) begin
                    state_next = (idx_reg >= IW'(2)) ? ST_LOAD : ST_TOP;
                end
            end
            ST_LOAD:  state_next = ST_DELTA;
            ST_DELTA: state_next = ST_MUL;
            ST_MUL:   state_next = ST_UPD;
            ST_UPD:   state_next = (cnt_p1 < idx_m1) ? ST_DELTA : ST_TOP;
            ST_TOP:   state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            cnt_reg     <= '0;
            idx_reg     <= IW'(CELLS);
            prev_reg    <= IW'(CELLS);
            level_reg   <= LW'(CELLS) << FW16;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_INIT: begin
                    cnt_reg <= (cnt_reg == IW'(CELLS - 1)) ? '0 : cnt_p1;
                end
                ST_IDLE: begin
                    cnt_reg <= '0;
                    if (s_fire && s_kind == mbd_pkg::KIND_STEP) begin
                        idx_reg <= idx_new;
                    end
                end
                ST_SUM: begin
                    cnt_reg <= (cnt_reg == IW'(CELLS)) ? '0 : cnt_p1;
                end
                ST_UPD: begin
                    cnt_reg <= cnt_p1;
                end
                ST_TOP: begin
                    prev_reg <= idx_reg;
                    if (drop_ext >= level_ext) begin
                        level_reg <= '0;
                    end else begin
                        level_reg <= LW'(level_ext - drop_ext);
                    end
                end
                ST_READ, ST_LOAD, ST_DELTA, ST_MUL, ST_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                r_reg        <= s_r;
                drop_reg     <= s_drop;
                rd_ok_reg    <= (32'(s_cell) < CELLS);
                total_reg    <= '0;
                gathered_reg <= '0;
                below_reg    <= '0;
            end
            ST_READ: begin
                res_value_reg <= rd_ok_reg ? ram_rd_data : '0;
            end
            ST_SUM: begin
                if (sum_data_ok) begin
                    total_reg <= total_reg + SW'(ram_rd_data);
                    if (cnt_m1 >= idx_reg && cnt_m1 < prev_reg) begin
                        gathered_reg <= gathered_reg + SW'(ram_rd_data);
                    end
                end
            end
            ST_LOAD: begin
                // Reflective bottom: the cell below cell 0 mirrors cell 0.
                w_prev_reg <= SW'(ram_rd_data);
                w_cur_reg  <= SW'(ram_rd_data);
            end
            ST_DELTA: begin
                delta_reg  <= delta;
                w_next_reg <= s_next;
            end
            ST_UPD: begin
                below_reg  <= below_reg + SW'(fresh_sat);
                w_prev_reg <= w_cur_reg;
                w_cur_reg  <= w_next_reg;
            end
            ST_TOP: begin
                res_value_reg <= '0;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_value_reg <= res_value_reg;
                    m_level_reg <= mbd_pkg::LVLO_W'(level_rnd);
                end
            end
            ST_INIT, ST_MUL: begin
            end
            default: begin
            end
        endcase
    end

endmodule

### tb/sv/moving_boundary_diffusion_step_tb.sv
// ----------------------------------------------------------------------------
// moving_boundary_diffusion_step_tb: self-checking bench for the diffusion column
// A short table of step and read words covers the reset column, ignored fields,
// extreme diffusion numbers and the drained surface. About a thousand random
// words follow, with drops small enough to walk the surface down through the
// whole column. Each result is checked against its typed row or a local predictor.
// ----------------------------------------------------------------------------
module moving_boundary_diffusion_step_tb;

    localparam int CELLS        = mbd_pkg::CELLS_DEFAULT;
    localparam int RANDOM_WORDS = 1000;
    localparam int HEAD_ROWS    = 16;
    localparam int N_ROWS       = 23;
    localparam int SETTLE_CYCLES = 600;

    typedef struct packed {
        logic        kind;
        logic [15:0] dnum;
        logic [23:0] drop;
        logic [6:0]  cell_idx;
        logic        typed;
        logic [23:0] t_value;
        logic [7:0]  t_level;
    } stim_row_t;

    typedef struct packed {
        logic [23:0] cell_value;
        logic [7:0]  level_index;
    } column_reply_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [mbd_pkg::S_TDATA_W-1:0]   s_tdata  = '0;
    logic [0:0]                      s_tuser  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [mbd_pkg::M_TDATA_W-1:0]   m_tdata;

    column_reply_t pending_replies[$];
    column_reply_t want;
    int            errors = 0;
    bit            calm   = 1'b0;

    // Predicted column state.
    logic [23:0] model_conc [CELLS];
    logic [23:0] model_level;
    int          model_prev_idx;

    // The first HEAD_ROWS rows run right after reset, the rest close the run
    // because they drain the surface for good.
    stim_row_t stim_rows [N_ROWS] = '{
        '{mbd_pkg::KIND_READ, 16'h0000, 24'h000000, 7'd0,   1'b1, mbd_pkg::ONE_Q16, 8'd128},
        '{mbd_pkg::KIND_READ, 16'h0000, 24'h000000, 7'd127, 1'b1, mbd_pkg::ONE_Q16, 8'd128},
        '{mbd_pkg::KIND_READ, 16'hFFFF, 24'hFFFFFF, 7'h55,  1'b1, mbd_pkg::ONE_Q16, 8'd128},
        '{mbd_pkg::KIND_STEP, 16'h0000, 24'h000000, 7'd127, 1'b1, 24'h0,   8'd128},
        '{mbd_pkg::KIND_READ, 16'h0000, 24'h000000, 7'd64,  1'b1, mbd_pkg::ONE_Q16, 8'd128},
        '{mbd_pkg::KIND_STEP, 16'h8000, 24'h000000, 7'd0,   1'b1, 24'h0,   8'd128},
        '{mbd_pkg::KIND_READ, 16'h0000, 24'h000000, 7'd100, 1'b1, mbd_pkg::ONE_Q16, 8'd128},
        '{mbd_pkg::KIND_STEP, 16'h8000, 24'h008000, 7'd0,   1'b1, 24'h0,   8'd128},
        '{mbd_pkg::KIND_STEP, 16'h4000, 24'h010000, 7'd0,   1'b1, 24'h0,   8'd127},
        '{mbd_pkg::KIND_STEP, 16'h4000, 24'h000000, 7'd0,   1'b0, 24'h0,   8'd0},
        '{mbd_pkg::KIND_READ, 16'h0000, 24'h000000, 7'd127, 1'b1, 24'h0,   8'd127},
        '{mbd_pkg::KIND_READ, 16'h0000, 24'h000000, 7'd126, 1'b0, 24'h0,   8'd0},
        '{mbd_pkg::KIND_READ, 16'h0000, 24'h000000, 7'd125, 1'b0, 24'h0,   8'd0},
        '{mbd_pkg::KIND_STEP, 16'hFFFF, 24'h020000, 7'd3,   1'b0, 24'h0,   8'd0},
        '{mbd_pkg::KIND_STEP, 16'h8000, 24'h007FFF, 7'd0,   1'b0, 24'h0,   8'd0},
        '{mbd_pkg::KIND_READ, 16'h0000, 24'h000000, 7'd0,   1'b0, 24'h0,   8'd0},
        '{mbd_pkg::KIND_STEP, 16'h8000, 24'hFFFFFF, 7'd0,   1'b1, 24'h0,   8'd0},
        '{mbd_pkg::KIND_STEP, 16'h8000, 24'h000000, 7'd0,   1'b1, 24'h0,   8'd0},
        '{mbd_pkg::KIND_READ, 16'h0000, 24'h000000, 7'd1,   1'b1, 24'h0,   8'd0},
        '{mbd_pkg::KIND_READ, 16'h0000, 24'h000000, 7'd127, 1'b1, 24'h0,   8'd0},
        '{mbd_pkg::KIND_READ, 16'h0000, 24'h000000, 7'd0,   1'b0, 24'h0,   8'd0},
        '{mbd_pkg::KIND_STEP, 16'hFFFF, 24'h123456, 7'd0,   1'b1, 24'h0,   8'd0},
        '{mbd_pkg::KIND_READ, 16'h0000, 24'h000000, 7'd0,   1'b0, 24'h0,   8'd0}
    };

    moving_boundary_diffusion_step dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic int rounded_level();
        return (int'(model_level) + 32'h8000) >>> 16;
    endfunction

    function automatic longint clamp_cell(longint v);
        if (v < 0) return 0;
        if (v > longint'(mbd_pkg::MAX_CELL)) return longint'(mbd_pkg::MAX_CELL);
        return v;
    endfunction

    // Product of the diffusion number and a difference, rounded to nearest
    // with ties away from zero.
    function automatic longint stencil_term(longint d, longint r);
        longint mag;
        longint p;
        mag = (d < 0) ? -d : d;
        p = (mag * r + 32768) >>> 16;
        return (d < 0) ? -p : p;
    endfunction

    function automatic void diffuse_and_lower(logic [15:0] dnum, logic [23:0] drop);
        int     idx;
        int     prev;
        int     i;
        longint total;
        longint gathered;
        longint below;
        longint rr;
        longint top;
        longint snap [CELLS];
        longint fresh [CELLS];
        idx = rounded_level();
        prev = model_prev_idx;
        // A dry column keeps cell 0 wet, holding the whole total.
        if (idx < 1) idx = 1;
        if (idx > CELLS) idx = CELLS;
        if (prev > CELLS) prev = CELLS;
        total = 0;
        gathered = 0;
        below = 0;
        rr = longint'(dnum);
        for (i = 0; i < CELLS; i++) begin
            snap[i] = longint'(model_conc[i]);
            total += snap[i];
        end
        for (i = idx; i < prev; i++) gathered += snap[i];
        snap[idx-1] += gathered;
        if (idx >= 2) begin
            fresh[0] = clamp_cell(snap[0] + stencil_term(snap[1] - snap[0], rr));
            for (i = 1; i + 1 < idx; i++)
                fresh[i] = clamp_cell(snap[i] +
                    stencil_term(snap[i+1] - 2 * snap[i] + snap[i-1], rr));
            for (i = 0; i + 1 < idx; i++) begin
                model_conc[i] = fresh[i][23:0];
                below += fresh[i];
            end
        end
        top = clamp_cell(total - below);
        model_conc[idx-1] = top[23:0];
        for (i = idx; i < CELLS; i++) model_conc[i] = '0;
        model_prev_idx = idx;
        if (drop >= model_level) model_level = '0;
        else model_level = model_level - drop;
    endfunction

    function automatic column_reply_t predict_column_word(stim_row_t w);
        column_reply_t rep;
        rep.cell_value = '0;
        if (w.kind == mbd_pkg::KIND_STEP) diffuse_and_lower(w.dnum, w.drop);
        else if (int'(w.cell_idx) < CELLS) rep.cell_value = model_conc[w.cell_idx];
        rep.level_index = 8'(rounded_level());
        return rep;
    endfunction

    task automatic send_word(input stim_row_t w);
        column_reply_t rep;
        if (!calm && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 33);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.kind;
        s_tdata  <= {1'b0, w.cell_idx, w.drop, w.dnum};
        do @(posedge aclk); while (!s_tready);
        rep = predict_column_word(w);
        if (w.typed) begin
            rep.cell_value  = w.t_value;
            rep.level_index = w.t_level;
        end
        pending_replies = {pending_replies, rep};
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_replies.size() != 0);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_replies.pop_front();
                if (m_tdata[23:0] !== want.cell_value) begin
                    $display("%0t: cell_value expected %h got %h",
                             $time, want.cell_value, m_tdata[23:0]);
                    errors++;
                end
                if (m_tdata[31:24] !== want.level_index) begin
                    $display("%0t: level_index expected %0d got %0d",
                             $time, want.level_index, m_tdata[31:24]);
                    errors++;
                end
            end
        end
        m_tready <= calm || ($urandom_range(0, 99) >= 33);
    end

    initial begin
        int        n;
        int        roll;
        stim_row_t w;
        for (n = 0; n < CELLS; n++) model_conc[n] = mbd_pkg::ONE_Q16;
        model_level = 24'(CELLS << mbd_pkg::FRAC_W);
        model_prev_idx = CELLS;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (n = 0; n < HEAD_ROWS; n++) send_word(stim_rows[n]);
        wait_drained();

        // Drops average about a third of a cell, so the surface crosses the
        // whole column and then sits dry for the last part of the run.
        for (n = 0; n < RANDOM_WORDS; n++) begin
            calm = (n >= 450 && n < 600);
            if ($urandom_range(0, 99) == 0) wait_drained();
            w = '0;
            w.kind = ($urandom_range(0, 99) < 45) ? mbd_pkg::KIND_STEP : mbd_pkg::KIND_READ;
            w.dnum = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 32768))
                                                  : 16'($urandom_range(0, 65535));
            roll = $urandom_range(0, 99);
            if (roll < 10)      w.drop = '0;
            else if (roll < 95) w.drop = 24'($urandom_range(0, 'hA000));
            else                w.drop = 24'($urandom_range(0, 'h40000));
            w.cell_idx = 7'($urandom_range(0, 127));
            send_word(w);
        end
        calm = 1'b0;

        for (n = HEAD_ROWS; n < N_ROWS; n++) send_word(stim_rows[n]);
        s_tvalid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("%0t: timeout", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
